>>> rtl/bss_pkg.sv
package bss_pkg;

   localparam int OFF_W = 12;
   localparam int POS_W = 11;

   typedef enum logic [1:0] {
      CMD_PATTERN = 2'd0,
      CMD_TEXT    = 2'd1,
      CMD_SEARCH  = 2'd2
   } bss_cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADJUST,
      ST_CHECK,
      ST_SPAN,
      ST_BEGIN,
      ST_READ,
      ST_COMPARE,
      ST_DONE
   } bss_state_type;

   typedef struct packed {
      logic       en;
      logic       restart;
      logic [7:0] data;
   } bss_wr_type;

   typedef struct packed {
      logic             valid;
      logic             found;
      logic [POS_W-1:0] position;
   } bss_res_type;

endpackage

>>> rtl/bss_byte_store.sv
module bss_byte_store import bss_pkg::*; #(
   parameter int DEPTH = 64,
   parameter int LEN_W = $clog2(DEPTH + 1),
   parameter int A_W   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             reset,
   input  bss_wr_type       wr,
   input  logic [A_W-1:0]   rd_addr,
   output logic [7:0]       rd_data,
   output logic [LEN_W-1:0] length,
   output logic             overflow
);

   logic [7:0]       mem [DEPTH];
   logic [7:0]       rd_data_ff;
   logic [LEN_W-1:0] len_ff;
   logic [LEN_W-1:0] len_in;
   logic             ovf_ff;
   logic             ovf_in;
   logic [LEN_W-1:0] base;
   logic             room;

   assign base = wr.restart ? '0 : len_ff;
   assign room = base < LEN_W'(DEPTH);

   always_comb begin
      len_in = len_ff;
      ovf_in = ovf_ff;
      if (wr.en) begin
         if (room) begin
            len_in = base + LEN_W'(1);
         end else begin
            len_in = base;
            ovf_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
         ovf_ff <= 1'b0;
      end else begin
         len_ff <= len_in;
         ovf_ff <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en && room) begin
         mem[base[A_W-1:0]] <= wr.data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data  = rd_data_ff;
   assign length   = len_ff;
   assign overflow = ovf_ff;

endmodule

>>> rtl/bss_search_seq.sv
module bss_search_seq import bss_pkg::*; #(
   parameter int TEXT_DEPTH    = 1024,
   parameter int PATTERN_DEPTH = 64,
   parameter int TLEN_W        = $clog2(TEXT_DEPTH + 1),
   parameter int PLEN_W        = $clog2(PATTERN_DEPTH + 1),
   parameter int TA_W          = $clog2(TEXT_DEPTH),
   parameter int PA_W          = $clog2(PATTERN_DEPTH)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    go,
   input  logic signed [OFF_W-1:0] start_offset,
   input  logic signed [OFF_W-1:0] end_offset,
   input  logic [TLEN_W-1:0]       text_len,
   input  logic [PLEN_W-1:0]       pat_len,
   input  logic [7:0]              text_byte,
   input  logic [7:0]              pat_byte,
   input  logic                    res_taken,
   output logic [TA_W-1:0]         text_addr,
   output logic [PA_W-1:0]         pat_addr,
   output logic                    busy,
   output bss_res_type             res
);

   localparam int CW = ((TLEN_W > OFF_W) ? TLEN_W : OFF_W) + 2;

   bss_state_type          state_ff, state_in;
   logic signed [CW-1:0]   start_ff, start_in;
   logic signed [CW-1:0]   end_ff, end_in;
   logic signed [CW-1:0]   last_ff, last_in;
   logic signed [CW-1:0]   p_ff, p_in;
   logic [PLEN_W-1:0]      i_ff, i_in;
   logic                   found_ff, found_in;
   logic [POS_W-1:0]       pos_ff, pos_in;
   logic signed [CW-1:0]   blen_s;
   logic signed [CW-1:0]   plen_s;
   logic signed [CW-1:0]   taddr_sum;
   logic                   bad_range;
   logic                   byte_eq;
   logic                   last_idx;

   assign blen_s    = CW'(text_len);
   assign plen_s    = CW'(pat_len);
   assign bad_range = (start_ff < 0) || (end_ff <= start_ff);
   assign byte_eq   = text_byte == pat_byte;
   assign last_idx  = i_ff == (pat_len - PLEN_W'(1));
   assign taddr_sum = p_ff + CW'(i_ff);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:    if (go) state_in = ST_ADJUST;
         ST_ADJUST:  state_in = ST_CHECK;
         ST_CHECK: begin
            if (bad_range || pat_len == '0) state_in = ST_DONE;
            else state_in = ST_SPAN;
         end
         ST_SPAN:    state_in = ST_BEGIN;
         ST_BEGIN: begin
            if (start_ff > last_ff) state_in = ST_DONE;
            else state_in = ST_READ;
         end
         ST_READ:    state_in = ST_COMPARE;
         ST_COMPARE: begin
            if (byte_eq && last_idx) state_in = ST_DONE;
            else if (!byte_eq && p_ff == last_ff) state_in = ST_DONE;
            else state_in = ST_READ;
         end
         ST_DONE:    if (res_taken) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      start_in = start_ff;
      end_in   = end_ff;
      last_in  = last_ff;
      p_in     = p_ff;
      i_in     = i_ff;
      found_in = found_ff;
      pos_in   = pos_ff;
      case (state_ff)
         ST_IDLE: begin
            if (go) begin
               start_in = CW'(start_offset);
               end_in   = CW'(end_offset);
               found_in = 1'b0;
               pos_in   = '0;
            end
         end
         ST_ADJUST: begin
            if (start_ff < 0) start_in = start_ff + blen_s;
            if (end_ff < 0) end_in = end_ff + blen_s + CW'(1);
         end
         ST_CHECK: begin
            if (!bad_range) begin
               if (end_ff > blen_s) end_in = blen_s;
               if (pat_len == '0) begin
                  found_in = 1'b1;
                  pos_in   = start_ff[POS_W-1:0];
               end
            end
         end
         ST_SPAN:  last_in = end_ff - plen_s;
         ST_BEGIN: begin
            p_in = start_ff;
            i_in = '0;
         end
         ST_COMPARE: begin
            if (byte_eq) begin
               if (last_idx) begin
                  found_in = 1'b1;
                  pos_in   = p_ff[POS_W-1:0];
               end else begin
                  i_in = i_ff + PLEN_W'(1);
               end
            end else begin
               p_in = p_ff + CW'(1);
               i_in = '0;
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      text_addr = taddr_sum[TA_W-1:0];
      pat_addr  = i_ff[PA_W-1:0];
      busy      = state_ff != ST_IDLE;
      res.valid    = state_ff == ST_DONE;
      res.found    = found_ff;
      res.position = pos_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      start_ff <= start_in;
      end_ff   <= end_in;
      last_ff  <= last_in;
      p_ff     <= p_in;
      i_ff     <= i_in;
      found_ff <= found_in;
      pos_ff   <= pos_in;
   end

endmodule

>>> rtl/byte_substring_search.sv
// channel | dir | valid/ready            | payload
// req     | in  | req_tvalid/req_tready  | tdata, tuser
// rsp     | out | rsp_tvalid/rsp_tready  | tdata, tuser
//
// Each load carries one byte; req_tready stays high while no search runs.
// A search adjusts and checks the offsets, clamps the end and sets the last window
// start, then for each byte compare reads text and pattern memory, then compares;
// finally it hands off the result word. req_tready is low meanwhile.
// Reset clears lengths, truncation flag and the sequencer; stores are not cleared.
// A waiting rsp word does not block loads; a finished search waits for it.
module byte_substring_search import bss_pkg::*; #(
   parameter int TEXT_DEPTH    = 1024,
   parameter int PATTERN_DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // data_byte, start_offset, end_offset
   input  logic [2:0]  req_tuser,   // command, first_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // match_position, zero fill
   output logic [1:0]  rsp_tuser    // found, truncated
);

   localparam int TLEN_W = $clog2(TEXT_DEPTH + 1);
   localparam int PLEN_W = $clog2(PATTERN_DEPTH + 1);
   localparam int TA_W   = $clog2(TEXT_DEPTH);
   localparam int PA_W   = $clog2(PATTERN_DEPTH);

   logic              accept;
   bss_cmd_type       command;
   logic              go;
   bss_wr_type        text_wr, pat_wr;
   logic [TA_W-1:0]   text_addr;
   logic [PA_W-1:0]   pat_addr;
   logic [7:0]        text_byte, pat_byte;
   logic [TLEN_W-1:0] text_len;
   logic [PLEN_W-1:0] pat_len;
   logic              text_ovf, pat_ovf;
   logic              busy;
   bss_res_type       res;
   logic              res_taken;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_found_ff;
   logic              rsp_trunc_ff;
   logic [POS_W-1:0]  rsp_pos_ff;

   assign req_tready = !busy;
   assign accept     = req_tvalid && req_tready;
   assign command    = bss_cmd_type'(req_tuser[1:0]);

   always_comb begin
      text_wr.en      = 1'b0;
      text_wr.restart = req_tuser[2];
      text_wr.data    = req_tdata[7:0];
      pat_wr.en       = 1'b0;
      pat_wr.restart  = req_tuser[2];
      pat_wr.data     = req_tdata[7:0];
      go              = 1'b0;
      if (accept) begin
         unique case (command)
            CMD_PATTERN: pat_wr.en  = 1'b1;
            CMD_TEXT:    text_wr.en = 1'b1;
            CMD_SEARCH:  go         = 1'b1;
            default:     ;
         endcase
      end
   end

   bss_byte_store #(.DEPTH(TEXT_DEPTH)) u_text (
      .clock    (clock),
      .reset    (reset),
      .wr       (text_wr),
      .rd_addr  (text_addr),
      .rd_data  (text_byte),
      .length   (text_len),
      .overflow (text_ovf)
   );

   bss_byte_store #(.DEPTH(PATTERN_DEPTH)) u_pattern (
      .clock    (clock),
      .reset    (reset),
      .wr       (pat_wr),
      .rd_addr  (pat_addr),
      .rd_data  (pat_byte),
      .length   (pat_len),
      .overflow (pat_ovf)
   );

   bss_search_seq #(
      .TEXT_DEPTH    (TEXT_DEPTH),
      .PATTERN_DEPTH (PATTERN_DEPTH)
   ) u_seq (
      .clock        (clock),
      .reset        (reset),
      .go           (go),
      .start_offset (req_tdata[19:8]),
      .end_offset   (req_tdata[31:20]),
      .text_len     (text_len),
      .pat_len      (pat_len),
      .text_byte    (text_byte),
      .pat_byte     (pat_byte),
      .res_taken    (res_taken),
      .text_addr    (text_addr),
      .pat_addr     (pat_addr),
      .busy         (busy),
      .res          (res)
   );

   assign res_taken = res.valid && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res_taken) rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_taken) begin
         rsp_found_ff <= res.found;
         rsp_pos_ff   <= res.position;
         rsp_trunc_ff <= text_ovf || pat_ovf;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(16 - POS_W){1'b0}}, rsp_pos_ff};
   assign rsp_tuser  = {rsp_trunc_ff, rsp_found_ff};

`ifndef SYNTHESIS
   a_busy_after_search: assert property (@(posedge clock) disable iff (reset)
      (accept && command == CMD_SEARCH) |=> !req_tready)
      else $error("search accepted but block still ready");

   a_result_waits: assert property (@(posedge clock) disable iff (reset)
      (res.valid && rsp_valid_ff && !rsp_tready) |=> res.valid)
      else $error("finished search dropped while output word pending");

   a_no_pos_when_missing: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[0]) |-> (rsp_tdata == 16'd0))
      else $error("position nonzero on a miss");
`endif

endmodule
